### rtl/mexp_pkg.sv
// mexp_pkg: shared types and constants of the modular exponentiation unit
// command and status bundles between controller and datapath
// no dependencies
`default_nettype none

package mexp_pkg;

  // width of the base operand and of the result
  localparam int unsigned BASE_W = 32;
  localparam int unsigned RES_W = 32;

  // modulus after reset, ten to the ninth plus seven
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch a new item, prepare base reduction
    logic init;       // prepare one modular multiplication
    logic step;       // one shift-add step of the shared unit
    logic reduce;     // step belongs to the base reduction
    logic sel_sq;     // multiplication squares the power
    logic exp_shift;  // drop the lowest exponent bit
    logic finish;     // capture the result
  } mexp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic cnt_last;
  } mexp_status_t;

endpackage

`default_nettype wire

### rtl/mexp_ctrl.sv
// mexp_ctrl: sequencer of the square and multiply loop
// depends on mexp_pkg
`default_nettype none

module mexp_ctrl import mexp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire mexp_status_t status,
  output mexp_cmd_t         cmd,
  output logic              busy,
  output logic              out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_MUL,
    S_SQ_INIT,
    S_SQR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.step   = 1'b1;
        cmd.reduce = 1'b1;
        if (status.cnt_last) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status.exp_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (status.exp_lsb) begin
          cmd.init  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.init   = 1'b1;
          cmd.sel_sq = 1'b1;
          state_nxt  = S_SQR;
        end
      end
      S_MUL: begin
        cmd.step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = S_SQ_INIT;
        end
      end
      S_SQ_INIT: begin
        cmd.init   = 1'b1;
        cmd.sel_sq = 1'b1;
        state_nxt  = S_SQR;
      end
      S_SQR: begin
        cmd.step      = 1'b1;
        cmd.sel_sq    = 1'b1;
        cmd.exp_shift = status.cnt_last;
        if (status.cnt_last) begin
          state_nxt = S_NEXT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/mexp_datapath.sv
// mexp_datapath: operand registers, modulus register and the shared
// shift-add modular step unit; depends on mexp_pkg
`default_nettype none

module mexp_datapath import mexp_pkg::*; #(
  parameter int unsigned EXP_BITS = 63,
  parameter int unsigned MOD_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mexp_cmd_t           cmd,
  output mexp_status_t             status,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [BASE_W-1:0]   base_value,
  input  wire logic [EXP_BITS-1:0] exponent,
  output logic [RES_W-1:0]         power_result
);

  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned SH = (W > BASE_W) ? W : BASE_W;
  localparam int unsigned CW = $clog2(SH);

  logic [W-1:0]        mod_r;
  logic [W:0]          m_r;
  logic [W-1:0]        base_r;
  logic [W-1:0]        acc_r;
  logic [W-1:0]        prod_r;
  logic [SH-1:0]       sh_r;
  logic [CW-1:0]       cnt_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [RES_W-1:0]    res_r;

  logic [63:0]  cfg_ext;
  logic [63:0]  acc_ext;
  logic [W-1:0] mul_a;
  logic [W-1:0] addend;
  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W+1:0] red;
  logic [W-1:0] step_res;
  logic         one_mod;

  assign cfg_ext = 64'(cfg_data);
  assign acc_ext = 64'(acc_r);
  assign one_mod = (mod_r == W'(1));

  // step: prod = (2*prod + addend) mod m, sum stays below 3m
  assign mul_a  = cmd.sel_sq ? base_r : acc_r;
  assign addend = !sh_r[SH-1] ? '0 : (cmd.reduce ? W'(1) : mul_a);
  assign sum    = {1'b0, prod_r, 1'b0} + {2'b00, addend};
  assign m1     = {1'b0, m_r};
  assign m2     = {m_r, 1'b0};

  always_comb begin
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  assign step_res = red[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RESET[W-1:0];
    end else if (cfg_we) begin
      mod_r <= cfg_ext[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // modulus zero stands for two to the width
      m_r    <= (mod_r == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_r};
      sh_r   <= SH'(base_value) << (SH - BASE_W);
      cnt_r  <= CW'(BASE_W - 1);
      prod_r <= '0;
      exp_r  <= exponent;
      acc_r  <= ((exponent != '0) && one_mod) ? '0 : W'(1);
    end else if (cmd.init) begin
      sh_r   <= SH'(base_r) << (SH - W);
      cnt_r  <= CW'(W - 1);
      prod_r <= '0;
    end else if (cmd.step) begin
      sh_r   <= sh_r << 1;
      cnt_r  <= cnt_r - CW'(1);
      prod_r <= step_res;
      if (cnt_r == '0) begin
        if (cmd.reduce || cmd.sel_sq) begin
          base_r <= step_res;
        end else begin
          acc_r <= step_res;
        end
      end
      if (cmd.exp_shift) begin
        exp_r <= exp_r >> 1;
      end
    end
    if (cmd.finish) begin
      res_r <= acc_ext[RES_W-1:0];
    end
  end

  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.cnt_last = (cnt_r == '0);
  assign power_result    = res_r;

endmodule

`default_nettype wire

### rtl/modular_exponentiation_unit.sv
// modular_exponentiation_unit: top level, controller plus datapath
// depends on mexp_pkg, mexp_ctrl, mexp_datapath
`default_nettype none

// Computes base to the exponent modulo the configured modulus by right-to-left
// square and multiply. Pulse start while busy is low to hand in one beat; the
// result shows on out_power_result for exactly one cycle with out_valid high,
// and the receiver cannot stall it, so it must take it on that cycle. A new
// beat may be started in the cycle the result strobes. Sequence: a load, the
// base reduction, then for each exponent bit up to the highest set one a
// squaring (clear bit) or a multiplication and then a squaring (set bit), and
// a final step; all modular products go through one shared shift-add unit
// that retires one multiplier bit per cycle. A zero exponent returns 1.
// The modulus register resets to 1000000007 and is written through the cfg
// port; the user must write it only while the unit is idle, which the block
// does not enforce. A modulus of zero means two to MOD_BITS.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int unsigned EXP_BITS = 63,
  parameter int unsigned MOD_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // item channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [BASE_W-1:0]   in_base_value,
  input  wire logic [EXP_BITS-1:0] in_exponent,
  // result channel
  output logic                     out_valid,
  output logic [RES_W-1:0]         out_power_result,
  // modulus write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_modulus
);

  mexp_cmd_t    cmd;
  mexp_status_t status;

  // modulus writes are always taken
  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mexp_datapath #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_modulus),
    .base_value   (in_base_value),
    .exponent     (in_exponent),
    .power_result (out_power_result)
  );

endmodule

`default_nettype wire
